// File: src/mtf_pkg.sv
package mtf_pkg;

  // Default list geometry.
  localparam int DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF = 64;

  // Fixed field widths of the item formats.
  localparam int WORD_BITS = 64;
  localparam int POS_BITS = 4;
  localparam int POS_SPAN = 1 << POS_BITS;
  localparam int FILL_BITS = 5;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_FIND   = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_IDLE   = 2'd3
  } func_t;

  typedef struct packed {
    func_t                 func;
    logic [WORD_BITS-1:0]  key_word;
    logic [WORD_BITS-1:0]  phone_word;
    logic [WORD_BITS-1:0]  address_word;
    logic [POS_BITS-1:0]   position;
  } in_item_t;

  typedef struct packed {
    logic                  hit;
    logic [WORD_BITS-1:0]  out_key;
    logic [WORD_BITS-1:0]  out_phone;
    logic [WORD_BITS-1:0]  out_address;
    logic                  dropped;
    logic [FILL_BITS-1:0]  fill;
  } out_item_t;

  // Operation strobes broadcast to every cell, already qualified by acceptance.
  typedef struct packed {
    logic insert;
    logic find;
    logic read;
  } cell_ctl_t;

endpackage

// File: src/mtf_cell.sv
module mtf_cell
  import mtf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int IDX = 0,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic                 found_all,
  input  logic [KEY_BITS-1:0]  search_key,
  input  logic [POS_BITS-1:0]  position,
  input  logic [CW-1:0]        count,
  input  logic [KEY_BITS-1:0]  prev_key,
  input  logic [WORD_BITS-1:0] prev_phone,
  input  logic [WORD_BITS-1:0] prev_address,
  input  logic                 seen_in,
  output logic                 seen_out,
  input  logic [KEY_BITS-1:0]  pick_key_in,
  input  logic [WORD_BITS-1:0] pick_phone_in,
  input  logic [WORD_BITS-1:0] pick_address_in,
  output logic [KEY_BITS-1:0]  pick_key_out,
  output logic [WORD_BITS-1:0] pick_phone_out,
  output logic [WORD_BITS-1:0] pick_address_out,
  output logic [KEY_BITS-1:0]  own_key,
  output logic [WORD_BITS-1:0] own_phone,
  output logic [WORD_BITS-1:0] own_address
);

  localparam bit POS_REACH = (IDX < POS_SPAN);

  logic occupied;
  logic match;
  logic first;
  logic pos_eq;
  logic sel;
  logic shift;

  assign occupied = (count > CW'(IDX));
  assign match    = ctl.find && occupied && (own_key == search_key);
  assign first    = match && !seen_in;
  assign seen_out = seen_in || match;
  assign pos_eq   = POS_REACH && (position == POS_BITS'(IDX));
  assign sel      = first || (ctl.read && occupied && pos_eq);

  // Selected record is merged into the pick bus that runs along the row.
  assign pick_key_out     = pick_key_in | ({KEY_BITS{sel}} & own_key);
  assign pick_phone_out   = pick_phone_in | ({WORD_BITS{sel}} & own_phone);
  assign pick_address_out = pick_address_in | ({WORD_BITS{sel}} & own_address);

  // On an insert every cell takes its neighbour's record; on a find hit, cells up to the frontmost match do.
  assign shift = ctl.insert || (ctl.find && found_all && !seen_in);

  always_ff @(posedge clk) begin
    if (shift) begin
      own_key     <= prev_key;
      own_phone   <= prev_phone;
      own_address <= prev_address;
    end
  end

endmodule

// File: src/move_to_front_record_list_core.sv
// A result is registered in the cycle after its item is accepted.
// One item is taken per cycle while the output is not stalled; the rate is set by
// the row of cells, which compares every key and shifts the whole list at once.
// Reset clears the record count (list empty) and the output valid flag; the
// record stores are not cleared and hold undefined data until written.
module move_to_front_record_list_core
  import mtf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CW = $clog2(DEPTH + 1);

  // The list itself lives in a row of identical cells. Cell 0 is the front.
  // Each cell hands its record to the next one back, and two chains run the
  // length of the row: the seen chain, which marks that a match has already
  // been found nearer the front, and the pick bus, which gathers the record
  // chosen by a find or a read.

  logic            accept;
  cell_ctl_t       ctl;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            found_all;
  logic            read_hit;
  logic            full;
  logic [KEY_BITS-1:0] search_key;

  logic [KEY_BITS-1:0]  front_key;
  logic [WORD_BITS-1:0] front_phone;
  logic [WORD_BITS-1:0] front_address;

  logic [KEY_BITS-1:0]  own_key     [DEPTH];
  logic [WORD_BITS-1:0] own_phone   [DEPTH];
  logic [WORD_BITS-1:0] own_address [DEPTH];

  logic                 seen         [DEPTH+1];
  logic [KEY_BITS-1:0]  pick_key     [DEPTH+1];
  logic [WORD_BITS-1:0] pick_phone   [DEPTH+1];
  logic [WORD_BITS-1:0] pick_address [DEPTH+1];

  out_item_t result;

  // The output register is the only buffer: a new item is taken whenever the
  // register is empty or its item is being taken in the same cycle.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign ctl.insert = accept && (in_item.func == FUNC_INSERT);
  assign ctl.find   = accept && (in_item.func == FUNC_FIND);
  assign ctl.read   = accept && (in_item.func == FUNC_READ);

  // Key bits above KEY_BITS play no part in storing or comparing.
  assign search_key = in_item.key_word[KEY_BITS-1:0];

  assign seen[0]         = 1'b0;
  assign pick_key[0]     = '0;
  assign pick_phone[0]   = '0;
  assign pick_address[0] = '0;
  assign found_all       = seen[DEPTH];

  // The record that enters the front: the new one on an insert, otherwise the
  // frontmost match of a find. Cells only load on those two operations.
  always_comb begin
    if (ctl.insert) begin
      front_key     = search_key;
      front_phone   = in_item.phone_word;
      front_address = in_item.address_word;
    end else begin
      front_key     = pick_key[DEPTH];
      front_phone   = pick_phone[DEPTH];
      front_address = pick_address[DEPTH];
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]  prev_key;
    logic [WORD_BITS-1:0] prev_phone;
    logic [WORD_BITS-1:0] prev_address;

    if (i == 0) begin : g_front
      assign prev_key     = front_key;
      assign prev_phone   = front_phone;
      assign prev_address = front_address;
    end else begin : g_back
      assign prev_key     = own_key[i-1];
      assign prev_phone   = own_phone[i-1];
      assign prev_address = own_address[i-1];
    end

    mtf_cell #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS),
      .IDX      (i)
    ) u_cell (
      .clk              (clk),
      .ctl              (ctl),
      .found_all        (found_all),
      .search_key       (search_key),
      .position         (in_item.position),
      .count            (count),
      .prev_key         (prev_key),
      .prev_phone       (prev_phone),
      .prev_address     (prev_address),
      .seen_in          (seen[i]),
      .seen_out         (seen[i+1]),
      .pick_key_in      (pick_key[i]),
      .pick_phone_in    (pick_phone[i]),
      .pick_address_in  (pick_address[i]),
      .pick_key_out     (pick_key[i+1]),
      .pick_phone_out   (pick_phone[i+1]),
      .pick_address_out (pick_address[i+1]),
      .own_key          (own_key[i]),
      .own_phone        (own_phone[i]),
      .own_address      (own_address[i])
    );
  end

  // When the list is full an insert keeps the count and the rear record falls
  // off the end of the row.
  assign full = (count == CW'(DEPTH));

  always_comb begin
    count_next = count;
    if (ctl.insert && !full) begin
      count_next = count + CW'(1);
    end
  end

  // A read hits when the position lies below the record count; the count never
  // exceeds DEPTH, so this also keeps the position inside the row.
  assign read_hit = ({{CW{1'b0}}, in_item.position} < {{POS_BITS{1'b0}}, count});

  always_comb begin
    result.hit         = (ctl.find && found_all) || (ctl.read && read_hit);
    result.out_key     = WORD_BITS'(pick_key[DEPTH]);
    result.out_phone   = pick_phone[DEPTH];
    result.out_address = pick_address[DEPTH];
    result.dropped     = ctl.insert && full;
    result.fill        = FILL_BITS'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
    end
  end

  // The record count stays within the row.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("record count exceeds the list depth");

  // Every accepted item leaves a result in the output register.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  // A drop only happens on a full list, which then stays full.
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.dropped) |-> (out_item.fill == FILL_BITS'(DEPTH)))
    else $error("drop reported without a full list");

  // A hit never comes from an insert, so it never goes with a drop.
  a_hit_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.hit) |-> !out_item.dropped)
    else $error("hit and drop reported together");

endmodule
